FILE: hdl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Holds the request kind codes, the queue entry layout and the lead-byte masks.
// Depends on nothing.
package u8d_pkg;

   localparam int ByteWidth   = 8;
   localparam int CodeWidth   = 31;
   localparam int LenWidth    = 3;
   localparam int ReqDataW    = 8;
   localparam int RspDataW    = 40;
   localparam int RspPadW     = RspDataW - CodeWidth - LenWidth;

   localparam logic [7:0] LeadMask6 = 8'hfc;
   localparam logic [7:0] LeadMask5 = 8'hf8;
   localparam logic [7:0] LeadMask4 = 8'hf0;
   localparam logic [7:0] LeadMask3 = 8'he0;
   localparam logic [7:0] LeadMask2 = 8'hc0;
   localparam logic [7:0] ContMask  = 8'h3f;

   localparam logic [LenWidth-1:0] LenOne    = 3'd1;
   localparam logic [LenWidth-1:0] MaxExtra  = 3'd5;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_LEAD,
      KIND_MID,
      KIND_LAST
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [ByteWidth-1:0]    data;
      logic [LenWidth-1:0]     total;
   } entry_type;

endpackage

FILE: hdl/u8d_front.sv
// Front end of the UTF-8 stream decoder: accepts bytes and classifies them.
// Tracks the open sequence length and pushes one tagged entry per byte.
// Depends on u8d_pkg.
module u8d_front import u8d_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ByteWidth-1:0] req_byte,
   input  logic                 queue_full,
   output logic                 push,
   output entry_type            push_entry
);

   logic [LenWidth-1:0] pending_ff, pending_in;
   logic [LenWidth-1:0] total_ff, total_in;
   entry_type           entry;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;
   assign push_entry = entry;

   always_comb begin
      entry.kind  = KIND_PLAIN;
      entry.data  = req_byte;
      entry.total = LenOne;
      pending_in  = pending_ff;
      total_in    = total_ff;
      if (pending_ff != '0) begin
         entry.data  = req_byte & ContMask;
         entry.total = total_ff;
         entry.kind  = (pending_ff == LenOne) ? KIND_LAST : KIND_MID;
         pending_in  = pending_ff - LenOne;
      end else begin
         priority if ((req_byte & LeadMask6) == LeadMask6) begin
            entry.kind = KIND_LEAD;
            entry.data = req_byte & 8'h01;
            pending_in = 3'd5;
         end else if ((req_byte & LeadMask5) == LeadMask5) begin
            entry.kind = KIND_LEAD;
            entry.data = req_byte & 8'h03;
            pending_in = 3'd4;
         end else if ((req_byte & LeadMask4) == LeadMask4) begin
            entry.kind = KIND_LEAD;
            entry.data = req_byte & 8'h07;
            pending_in = 3'd3;
         end else if ((req_byte & LeadMask3) == LeadMask3) begin
            entry.kind = KIND_LEAD;
            entry.data = req_byte & 8'h0f;
            pending_in = 3'd2;
         end else if ((req_byte & LeadMask2) == LeadMask2) begin
            entry.kind = KIND_LEAD;
            entry.data = req_byte & 8'h1f;
            pending_in = 3'd1;
         end else begin
            entry.kind = KIND_PLAIN;
         end
         total_in = pending_in + LenOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         total_ff   <= '0;
      end else if (push) begin
         pending_ff <= pending_in;
         total_ff   <= total_in;
      end
   end

`ifndef SYNTH
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= MaxExtra)
      else $error("open sequence longer than six bytes");
`endif

endmodule

FILE: hdl/u8d_queue.sv
// Short request queue between the decoder front and back ends.
// Register-based circular buffer of tagged entries.
// Depends on u8d_pkg.
module u8d_queue import u8d_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      pop_valid,
   output entry_type pop_entry,
   input  logic      pop
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

   entry_type           slots_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_pop;

   assign full      = (count_ff == DepthCnt);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slots_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("request pushed into full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("queue count out of range");
`endif

endmodule

FILE: hdl/u8d_back.sv
// Back end of the UTF-8 stream decoder: assembles code points and holds results.
// Drains tagged entries from the queue into the accumulator and output register.
// Depends on u8d_pkg.
module u8d_back import u8d_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  entry_type            pop_entry,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CodeWidth-1:0] rsp_code,
   output logic [LenWidth-1:0]  rsp_len
);

   logic [CodeWidth-1:0] accum_ff, accum_in;
   logic [CodeWidth-1:0] code_ff, code_in;
   logic [LenWidth-1:0]  len_ff, len_in;
   logic                 valid_ff, valid_in;
   logic                 emits;
   logic [CodeWidth-1:0] shifted;

   assign emits   = (pop_entry.kind == KIND_PLAIN) || (pop_entry.kind == KIND_LAST);
   assign pop     = pop_valid && (!emits || !valid_ff || rsp_tready);
   assign shifted = {accum_ff[CodeWidth-7:0], pop_entry.data[5:0]};

   always_comb begin
      accum_in = accum_ff;
      code_in  = code_ff;
      len_in   = len_ff;
      valid_in = valid_ff && !rsp_tready;
      if (pop) begin
         unique case (pop_entry.kind)
            KIND_PLAIN: begin
               code_in  = CodeWidth'(pop_entry.data);
               len_in   = LenOne;
               valid_in = 1'b1;
            end
            KIND_LEAD: begin
               accum_in = CodeWidth'(pop_entry.data);
            end
            KIND_MID: begin
               accum_in = shifted;
            end
            KIND_LAST: begin
               code_in  = shifted;
               len_in   = pop_entry.total;
               accum_in = '0;
               valid_in = 1'b1;
            end
            default: begin
               accum_in = accum_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      len_ff  <= len_in;
      if (reset) begin
         valid_ff <= 1'b0;
         accum_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         accum_ff <= accum_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_code   = code_ff;
   assign rsp_len    = len_ff;

`ifndef SYNTH
   a_last_length: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_entry.kind == KIND_LAST) |->
         (pop_entry.total >= 3'd2 && pop_entry.total <= 3'd6))
      else $error("closing byte with bad sequence length");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready && pop) |-> !emits)
      else $error("held result overwritten");
`endif

endmodule

FILE: hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder, six-byte original form, one request byte per cycle while req_tready is high.
// Throughput: one byte per cycle sustained while rsp_tready is high; the front end, request queue
// and back end each take one byte per cycle, and the queue decouples stalls on either side.
// Result path: a closing byte goes through the request queue into the back-end output register on rsp.
// Reset: synchronous active high; clears the open sequence, the queue and the result valid.
module utf8_stream_decoder import u8d_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // [7:0] byte_in
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata    // [30:0] code_point, [33:31] seq_length, zero pad
);

   logic                 queue_full;
   logic                 push;
   entry_type            push_entry;
   logic                 pop_valid;
   entry_type            pop_entry;
   logic                 pop;
   logic [CodeWidth-1:0] rsp_code;
   logic [LenWidth-1:0]  rsp_len;

   u8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata[ByteWidth-1:0]),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   u8d_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   u8d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_code   (rsp_code),
      .rsp_len    (rsp_len)
   );

   assign rsp_tdata = {{RspPadW{1'b0}}, rsp_len, rsp_code};

endmodule
